>>> hw/rtl/pulse_speed_odometer_unit_defines.svh
`ifndef PULSE_SPEED_ODOMETER_UNIT_DEFINES_SVH
`define PULSE_SPEED_ODOMETER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define PSO_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PSO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pso_pkg.sv
package pso_pkg;

    localparam logic [1:0] REQ_SAMPLE     = 2'd0;
    localparam logic [1:0] REQ_PERIOD     = 2'd1;
    localparam logic [1:0] REQ_TRIP_RESET = 2'd2;
    localparam logic [1:0] REQ_TRIP_SET   = 2'd3;

    localparam logic [1:0] CFG_MM_PER_PULSE = 2'd0;
    localparam logic [1:0] CFG_ALPHA        = 2'd1;
    localparam logic [1:0] CFG_ODO_BASE     = 2'd2;

    localparam logic [15:0] MPP_RESET   = 16'd100;
    localparam logic [16:0] ALPHA_RESET = 17'd6554;
    localparam logic [16:0] ONE_Q16     = 17'd65536;

    localparam logic [31:0] MM_PER_KM     = 32'd1000000;
    localparam logic [31:0] TRIP_WRAP_MM  = 32'd1000000000;
    localparam logic [31:0] MM_PER_100M   = 32'd100000;
    localparam logic [16:0] TRIP_DIVISOR  = 17'd100000;
    localparam logic [16:0] SPEED_DIVISOR = 17'd10000;
    localparam logic [24:0] SPEED_SAT_Q   = 25'd18204445;
    localparam logic [13:0] TRIP_MAX      = 14'd9999;
    localparam logic [15:0] SPEED_MAX     = 16'hFFFF;

    localparam int unsigned DIV_REM_W = 17;
    localparam int unsigned DIV_DVD_W = 25;
    localparam int unsigned DIV_CNT_W = 5;

    typedef struct packed {
        logic                 start;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_CNT_W-1:0] nbits;
        logic [DIV_REM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic [DIV_DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hw/rtl/pso_serial_div.sv
module pso_serial_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  pso_pkg::div_req_t req,
    output pso_pkg::div_rsp_t rsp
);
    import pso_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [DIV_REM_W-1:0] divisor_reg, divisor_next;
    logic [DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_REM_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DIV_DVD_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        dvd_next     = dvd_reg;
        quo_next     = quo_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = req.nbits;
            rem_next     = req.rem_init;
            divisor_next = req.divisor;
            dvd_next     = req.dividend;
            quo_next     = '0;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring
            if (fits)
            begin
                rem_next = DIV_REM_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = trial[DIV_REM_W-1:0];
            end
            quo_next = {quo_reg[DIV_DVD_W-2:0], fits};
            dvd_next = {dvd_reg[DIV_DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> hw/rtl/pulse_speed_odometer_unit.sv
// channel   dir   handshake                  payload
// s_*       in    s_tvalid / s_tready        s_tuser req_type, s_tdata sample fields
// m_*       out   m_tvalid / m_tready        m_tdata speed, trip, odometer, step
// cfg_*     in    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// sample, trip reset and trip set beats: go from accept straight to the done state, then to the result register
// period beat: bit-serial multiplies (17 and 16 steps), then, if elapsed is nonzero and
// unsaturated, the one-bit-per-cycle divider (25 steps for rate, 16 for km/h)
// the trip divide (16 steps) runs beside the rate divide on a second divider
// reset is asynchronous and immediate, no clearing pass; a new beat is taken while
// the previous result waits in the output register, a stalled result holds it there
module pulse_speed_odometer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // pin_level, elapsed_ms[15:0], trip_value[13:0], pad
    input  logic [1:0]  s_tuser,    // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // speed_kmh, trip_100m, odometer_km, odometer_step, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import pso_pkg::*;

`include "pulse_speed_odometer_unit_defines.svh"

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EMA   = 4'd1;
    localparam logic [3:0] ST_DIST  = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_DIV1  = 4'd4;
    localparam logic [3:0] ST_DIV2  = 4'd5;
    localparam logic [3:0] ST_TRIPW = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    localparam logic [4:0] EMA_LAST    = 5'd16;
    localparam logic [4:0] DIST_LAST   = 5'd15;
    localparam logic [4:0] NBITS_RATE  = 5'd25;
    localparam logic [4:0] NBITS_SCALE = 5'd16;
    localparam logic [4:0] NBITS_TRIP  = 5'd16;

    logic [1:0]  s_req;
    logic        s_level;
    logic [15:0] s_elapsed;
    logic [13:0] s_trip_value;
    logic        in_beat;
    logic        cfg_beat;
    logic        out_load;

    logic [3:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic [15:0] mpp_reg;
    logic [16:0] alpha_reg;
    logic [23:0] base_reg;

    logic        primed_reg, primed_next;
    logic        last_level_reg, last_level_next;
    logic [15:0] edge_count_reg, edge_count_next;
    logic [31:0] smoothed_reg, smoothed_next;
    logic [31:0] km_accum_reg, km_accum_next;
    logic [31:0] trip_mm_reg, trip_mm_next;
    logic [23:0] km_counted_reg, km_counted_next;
    logic [15:0] speed_reg, speed_next;
    logic [13:0] trip_q_reg, trip_q_next;
    logic        step_reg, step_next;

    logic [15:0]        el_reg, el_next;
    logic signed [34:0] acc_reg, acc_next;
    logic signed [32:0] mcand_reg, mcand_next;
    logic [16:0]        mplier_reg, mplier_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [55:0]        m_tdata_reg;

    logic signed [32:0] ema_diff;
    logic [16:0]        alpha_sat;
    logic signed [34:0] mcand_ext;
    logic signed [34:0] mul_sum;
    logic signed [34:0] mul_shift;
    logic [31:0]        new_sc;

    logic [31:0] dist_mm;
    logic [31:0] km_sum;
    logic        km_wrap;
    logic [31:0] trip_sum;
    logic [31:0] trip_new;
    logic [41:0] prod_n;
    logic        n_sat;
    logic [24:0] q_rate;
    logic        q_sat;
    logic [29:0] scaled;
    logic [24:0] tq;
    logic [13:0] tq_sat;
    logic [23:0] odo_sum;

    div_req_t spd_req, trip_req;
    div_rsp_t spd_rsp, trip_rsp;

    assign s_req        = s_tuser;
    assign s_level      = s_tdata[0];
    assign s_elapsed    = s_tdata[16:1];
    assign s_trip_value = s_tdata[30:17];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // ema and distance multiply, lsb first, low product bits shift out
    assign ema_diff  = $signed({1'b0, edge_count_reg, 16'h0000}) - $signed({1'b0, smoothed_reg});
    assign alpha_sat = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
    assign mcand_ext = {{2{mcand_reg[32]}}, mcand_reg};
    assign mul_sum   = acc_reg + (mplier_reg[0] ? mcand_ext : 35'sd0);
    assign mul_shift = mul_sum >>> 1;
    assign new_sc    = smoothed_reg + mul_sum[31:0];

    assign dist_mm  = acc_reg[31:0];
    assign km_sum   = km_accum_reg + dist_mm;
    assign km_wrap  = km_sum >= MM_PER_KM;
    assign trip_sum = trip_mm_reg + dist_mm;
    assign trip_new = (trip_sum >= TRIP_WRAP_MM) ? (trip_sum - TRIP_WRAP_MM) : trip_sum;
    // dist_mm * 1000 as shifts
    assign prod_n   = {dist_mm, 10'b0} - {6'b0, dist_mm, 4'b0} - {7'b0, dist_mm, 3'b0};
    assign n_sat    = prod_n[41:25] >= {1'b0, el_reg};

    assign q_rate = spd_rsp.quotient;
    assign q_sat  = q_rate >= SPEED_SAT_Q;
    assign scaled = {q_rate, 5'b0} + {3'b0, q_rate, 2'b0};

    assign tq      = trip_rsp.quotient;
    assign tq_sat  = (tq > {11'b0, TRIP_MAX}) ? TRIP_MAX : tq[13:0];
    assign odo_sum = base_reg + km_counted_reg;

    pso_serial_div u_spd_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (spd_req),
        .rsp   (spd_rsp)
    );

    pso_serial_div u_trip_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (trip_req),
        .rsp   (trip_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        primed_next     = primed_reg;
        last_level_next = last_level_reg;
        edge_count_next = edge_count_reg;
        smoothed_next   = smoothed_reg;
        km_accum_next   = km_accum_reg;
        trip_mm_next    = trip_mm_reg;
        km_counted_next = km_counted_reg;
        speed_next      = speed_reg;
        trip_q_next     = trip_q_reg;
        step_next       = step_reg;
        el_next         = el_reg;
        acc_next        = acc_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        spd_req         = '0;
        trip_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    step_next  = 1'b0;
                    el_next    = s_elapsed;
                    state_next = ST_DONE;
                    unique case (s_req)
                        REQ_SAMPLE:
                        begin
                            if (!primed_reg)
                            begin
                                primed_next     = 1'b1;
                                last_level_next = s_level;
                            end
                            else if (s_level != last_level_reg)
                            begin
                                if (edge_count_reg != 16'hFFFF)
                                begin
                                    edge_count_next = edge_count_reg + 16'd1;
                                end
                                last_level_next = s_level;
                            end
                        end
                        REQ_PERIOD:
                        begin
                            acc_next    = '0;
                            mcand_next  = ema_diff;
                            mplier_next = alpha_sat;
                            cnt_next    = '0;
                            state_next  = ST_EMA;
                        end
                        REQ_TRIP_RESET:
                        begin
                            trip_mm_next = '0;
                            trip_q_next  = '0;
                        end
                        REQ_TRIP_SET:
                        begin
                            trip_mm_next = 32'(s_trip_value) * MM_PER_100M;
                            trip_q_next  = (s_trip_value > TRIP_MAX) ? TRIP_MAX : s_trip_value;
                        end
                    endcase
                end
            end
            ST_EMA:
            begin
                mplier_next = {1'b0, mplier_reg[16:1]};
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == EMA_LAST)
                begin
                    // top alpha bit has weight one, no shift
                    smoothed_next   = new_sc;
                    edge_count_next = '0;
                    acc_next        = '0;
                    mcand_next      = {1'b0, new_sc};
                    mplier_next     = {1'b0, mpp_reg};
                    cnt_next        = '0;
                    state_next      = ST_DIST;
                end
                else
                begin
                    acc_next = mul_shift;
                end
            end
            ST_DIST:
            begin
                acc_next    = mul_shift;
                mplier_next = {1'b0, mplier_reg[16:1]};
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == DIST_LAST)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (km_wrap)
                begin
                    km_accum_next   = km_sum - MM_PER_KM;
                    km_counted_next = km_counted_reg + 24'd1;
                    step_next       = 1'b1;
                end
                else
                begin
                    km_accum_next = km_sum;
                end
                trip_mm_next      = trip_new;
                trip_req.start    = 1'b1;
                trip_req.rem_init = {1'b0, trip_new[31:16]};
                trip_req.dividend = {trip_new[15:0], 9'b0};
                trip_req.nbits    = NBITS_TRIP;
                trip_req.divisor  = TRIP_DIVISOR;
                priority if (el_reg == 16'd0)
                begin
                    speed_next = '0;
                    state_next = ST_TRIPW;
                end
                else if (n_sat)
                begin
                    speed_next = SPEED_MAX;
                    state_next = ST_TRIPW;
                end
                else
                begin
                    spd_req.start    = 1'b1;
                    spd_req.rem_init = prod_n[41:25];
                    spd_req.dividend = prod_n[24:0];
                    spd_req.nbits    = NBITS_RATE;
                    spd_req.divisor  = {1'b0, el_reg};
                    state_next       = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (!spd_rsp.busy)
                begin
                    if (q_sat)
                    begin
                        speed_next = SPEED_MAX;
                        state_next = ST_TRIPW;
                    end
                    else
                    begin
                        spd_req.start    = 1'b1;
                        spd_req.rem_init = {3'b0, scaled[29:16]};
                        spd_req.dividend = {scaled[15:0], 9'b0};
                        spd_req.nbits    = NBITS_SCALE;
                        spd_req.divisor  = SPEED_DIVISOR;
                        state_next       = ST_DIV2;
                    end
                end
            end
            ST_DIV2:
            begin
                if (!spd_rsp.busy)
                begin
                    speed_next = q_rate[15:0];
                    state_next = ST_TRIPW;
                end
            end
            ST_TRIPW:
            begin
                if (!trip_rsp.busy)
                begin
                    trip_q_next = tq_sat;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            mpp_reg        <= MPP_RESET;
            alpha_reg      <= ALPHA_RESET;
            base_reg       <= '0;
            primed_reg     <= 1'b0;
            last_level_reg <= 1'b0;
            edge_count_reg <= '0;
            smoothed_reg   <= '0;
            km_accum_reg   <= '0;
            trip_mm_reg    <= '0;
            km_counted_reg <= '0;
            speed_reg      <= '0;
            trip_q_reg     <= '0;
            step_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            primed_reg     <= primed_next;
            last_level_reg <= last_level_next;
            edge_count_reg <= edge_count_next;
            smoothed_reg   <= smoothed_next;
            km_accum_reg   <= km_accum_next;
            trip_mm_reg    <= trip_mm_next;
            km_counted_reg <= km_counted_next;
            speed_reg      <= speed_next;
            trip_q_reg     <= trip_q_next;
            step_reg       <= step_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_beat)
            begin
                unique case (cfg_index)
                    CFG_MM_PER_PULSE: mpp_reg   <= cfg_data[15:0];
                    CFG_ALPHA:        alpha_reg <= cfg_data[16:0];
                    CFG_ODO_BASE:     base_reg  <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        el_reg     <= el_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        if (out_load)
        begin
            m_tdata_reg <= {1'b0, step_reg, odo_sum, trip_q_reg, speed_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PSO_ASSERT_NEXT(a_ema_to_dist, state_reg == ST_EMA && cnt_reg == EMA_LAST,
        state_reg == ST_DIST, "ema multiply did not hand over to distance multiply")
    `PSO_ASSERT_NEXT(a_trip_div_start, state_reg == ST_ACC, trip_rsp.busy,
        "trip divider not started on accumulate")
    `PSO_ASSERT_IMPL(a_tripw_spd_idle, state_reg == ST_TRIPW, !spd_rsp.busy,
        "speed divider still busy in trip wait")
    `PSO_ASSERT_NEXT(a_done_presents, out_load, m_tvalid_reg && state_reg == ST_IDLE,
        "result beat not presented after done")

endmodule
